@@ sv/tbo_pkg.sv @@
package tbo_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int TAG_BITS        = 16;
  localparam int CW              = 33;
  localparam int RW              = 72;
  localparam int PW              = 2 * RW + 1;
  localparam int HW              = RW / 2;
  localparam int PPW             = 2 * HW + 2;
  localparam int FACE_STAGES     = 8;

  localparam logic [15:0] TAG_MASK =
    (TAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TAG_BITS) - 32'd1);

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5,
    REG_LIMIT = 3'd6
  } reg_idx_e;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [RW-1:0] wide_t;

  typedef struct packed {
    wide_t n;
    wide_t d;
  } ratio_t;

  // half-word partial products of one wide product
  typedef struct packed {
    logic signed [PPW-1:0] hh;
    logic signed [PPW-1:0] hl;
    logic signed [PPW-1:0] lh;
    logic signed [PPW-1:0] ll;
  } pp_t;

  typedef struct packed {
    coord_t e1i;
    coord_t e1j;
    coord_t e1k;
    coord_t e2i;
    coord_t e2j;
    coord_t e2k;
    coord_t di;
    coord_t dj;
    coord_t dk;
    coord_t lenj;
    coord_t lenk;
  } face_in_t;

  // keep the denominator positive
  function automatic ratio_t mk_ratio(wide_t n, wide_t d);
    ratio_t r;
    if (d < 0) begin
      r.n = -n;
      r.d = -d;
    end else begin
      r.n = n;
      r.d = d;
    end
    return r;
  endfunction

  // x * y split into signed high and unsigned low halves
  function automatic pp_t mul_pp(wide_t x, wide_t y);
    pp_t                r;
    logic signed [HW:0] xh;
    logic signed [HW:0] xl;
    logic signed [HW:0] yh;
    logic signed [HW:0] yl;
    xh = {x[RW-1], x[RW-1:HW]};
    xl = {1'b0, x[HW-1:0]};
    yh = {y[RW-1], y[RW-1:HW]};
    yl = {1'b0, y[HW-1:0]};
    r.hh = PPW'(xh) * PPW'(yh);
    r.hl = PPW'(xh) * PPW'(yl);
    r.lh = PPW'(xl) * PPW'(yh);
    r.ll = PPW'(xl) * PPW'(yl);
    return r;
  endfunction

  function automatic logic signed [PW-1:0] pp_sum(pp_t p);
    return (PW'(p.hh) <<< (2 * HW)) + ((PW'(p.hl) + PW'(p.lh)) <<< HW) + PW'(p.ll);
  endfunction

  function automatic logic edge_big(wide_t v, logic [31:0] limit);
    logic [RW-1:0] m;
    m = (v < 0) ? RW'(-v) : RW'(v);
    return (m << COORD_FRAC_BITS) > RW'(limit);
  endfunction

endpackage

@@ sv/triangle_box_overlap_test.sv @@
// Triangle versus axis-aligned box overlap test.
// Box bounds (signed Q16.16) and the near-zero limit sit in registers written
// through cfg_we_i / cfg_idx_i / cfg_data_i; write them only while idle.
// Input channel in_valid_i / in_ready_o carries one triangle and two tags per
// transfer; output channel out_valid_o / out_ready_i returns one result per
// triangle, in order: tags, all/any vertex inside, face crossing.
// Stages from input transfer to out_valid_o: one difference stage, one edge-order
// stage, eight face-test stages per face, output register.
// One triangle per cycle while the output is not stalled; the six face tests run
// in parallel, each with its own multiply/compare stages.
// A stalled output freezes the whole pipeline and drops in_ready_o; nothing is
// lost or repeated. Reset empties the pipeline and loads the box [0,1]^3
// and a near-zero limit of one.
module triangle_box_overlap_test
  import tbo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] v0_x_i,
  input  logic signed [31:0] v0_y_i,
  input  logic signed [31:0] v0_z_i,
  input  logic signed [31:0] v1_x_i,
  input  logic signed [31:0] v1_y_i,
  input  logic signed [31:0] v1_z_i,
  input  logic signed [31:0] v2_x_i,
  input  logic signed [31:0] v2_y_i,
  input  logic signed [31:0] v2_z_i,
  input  logic [15:0]        object_tag_i,
  input  logic [15:0]        face_tag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        object_tag_out_o,
  output logic [15:0]        face_tag_out_o,
  output logic               all_vertices_inside_o,
  output logic               any_vertex_inside_o,
  output logic               crosses_face_o
);

  localparam int NSTG = FACE_STAGES + 2;

  typedef struct packed {
    logic [15:0] obj;
    logic [15:0] fce;
    logic        all_in;
    logic        any_in;
  } sb_t;

  logic signed [31:0] box_lo_q [3];
  logic signed [31:0] box_hi_q [3];
  logic [31:0]        limit_q;

  logic signed [31:0] vtx [3][3];
  logic [2:0]         vtx_in;

  coord_t e1_d [3], e1_q [3];
  coord_t e2_d [3], e2_q [3];
  coord_t dlo_d [3], dlo_q [3];
  coord_t dhi_d [3], dhi_q [3];
  coord_t len_d [3], len_q [3];
  coord_t c1 [3], c2 [3];
  coord_t tmp;
  coord_t p [3][3];
  coord_t q [3][3];

  sb_t             sb_d;
  sb_t             sb_q [NSTG];
  logic [NSTG-1:0] vld_q;
  logic            out_valid_q;
  logic [5:0]      hit;
  logic            en;

  sb_t             out_q;
  logic            cross_q;

  function automatic logic [CW-1:0] absval(coord_t v);
    return (v < 0) ? CW'(-v) : CW'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_lo_q[a] <= 32'sd0;
        box_hi_q[a] <= 32'sd65536;
      end
      limit_q <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_X: box_lo_q[0] <= cfg_data_i;
        REG_MAX_X: box_hi_q[0] <= cfg_data_i;
        REG_MIN_Y: box_lo_q[1] <= cfg_data_i;
        REG_MAX_Y: box_hi_q[1] <= cfg_data_i;
        REG_MIN_Z: box_lo_q[2] <= cfg_data_i;
        REG_MAX_Z: box_hi_q[2] <= cfg_data_i;
        REG_LIMIT: limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vtx[0][0] = v0_x_i;
  assign vtx[0][1] = v0_y_i;
  assign vtx[0][2] = v0_z_i;
  assign vtx[1][0] = v1_x_i;
  assign vtx[1][1] = v1_y_i;
  assign vtx[1][2] = v1_z_i;
  assign vtx[2][0] = v2_x_i;
  assign vtx[2][1] = v2_y_i;
  assign vtx[2][2] = v2_z_i;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: differences and vertex containment
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e1_d[a]  = CW'(vtx[1][a]) - CW'(vtx[0][a]);
      e2_d[a]  = CW'(vtx[2][a]) - CW'(vtx[0][a]);
      dlo_d[a] = CW'(box_lo_q[a]) - CW'(vtx[0][a]);
      dhi_d[a] = CW'(box_hi_q[a]) - CW'(vtx[0][a]);
      len_d[a] = CW'(box_hi_q[a]) - CW'(box_lo_q[a]);
    end
    for (int i = 0; i < 3; i++) begin
      vtx_in[i] = (vtx[i][0] >= box_lo_q[0]) && (vtx[i][0] <= box_hi_q[0]) &&
                  (vtx[i][1] >= box_lo_q[1]) && (vtx[i][1] <= box_hi_q[1]) &&
                  (vtx[i][2] >= box_lo_q[2]) && (vtx[i][2] <= box_hi_q[2]);
    end
    sb_d.obj    = object_tag_i & TAG_MASK;
    sb_d.fce    = face_tag_i & TAG_MASK;
    sb_d.all_in = &vtx_in;
    sb_d.any_in = |vtx_in;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      dlo_q <= dlo_d;
      dhi_q <= dhi_d;
      len_q <= len_d;
    end
  end

  // stage 2: edge order per axis, swaps carry to later axes
  always_comb begin
    tmp = '0;
    for (int i = 0; i < 3; i++) begin
      c1[i] = e1_q[i];
      c2[i] = e2_q[i];
    end
    for (int a = 0; a < 3; a++) begin
      if (absval(c1[a]) < absval(c2[a])) begin
        for (int i = 0; i < 3; i++) begin
          tmp   = c1[i];
          c1[i] = c2[i];
          c2[i] = tmp;
        end
      end
      for (int i = 0; i < 3; i++) begin
        p[a][i] = c1[i];
        q[a][i] = c2[i];
      end
    end
  end

  for (genvar f = 0; f < 6; f++) begin : g_face
    localparam int A       = f / 2;
    localparam int J       = (A + 1) % 3;
    localparam int K       = (A + 2) % 3;
    localparam bit HI_SIDE = (f % 2) == 1;

    face_in_t fin_d;
    face_in_t fin_q;

    always_comb begin
      fin_d.e1i  = p[A][A];
      fin_d.e1j  = p[A][J];
      fin_d.e1k  = p[A][K];
      fin_d.e2i  = q[A][A];
      fin_d.e2j  = q[A][J];
      fin_d.e2k  = q[A][K];
      fin_d.di   = HI_SIDE ? dhi_q[A] : dlo_q[A];
      fin_d.dj   = dlo_q[J];
      fin_d.dk   = dlo_q[K];
      fin_d.lenj = len_q[J];
      fin_d.lenk = len_q[K];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fin_q <= fin_d;
      end
    end

    tbo_face u_face (
      .clk_i   (clk_i),
      .en_i    (en),
      .limit_i (limit_q),
      .face_i  (fin_q),
      .hit_o   (hit[f])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], in_valid_i};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_d;
      for (int i = 1; i < NSTG; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      out_q   <= sb_q[NSTG-1];
      cross_q <= |hit;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign object_tag_out_o      = out_q.obj;
  assign face_tag_out_o        = out_q.fce;
  assign all_vertices_inside_o = out_q.all_in;
  assign any_vertex_inside_o   = out_q.any_in;
  assign crosses_face_o        = cross_q;

  a_all_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!all_vertices_inside_o || any_vertex_inside_o))
    else $error("all vertices inside without any vertex inside");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transfer not in first stage");

endmodule

@@ sv/tbo_face.sv @@
module tbo_face
  import tbo_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] limit_i,
  input  face_in_t    face_i,
  output logic        hit_o
);

  localparam int PRW = 2 * CW + 1;

  typedef logic signed [PRW-1:0] prod_t;
  typedef pp_t [7:0] flag_pp_t;

  typedef struct packed {
    ratio_t a;
    ratio_t b;
    logic   big;
    logic   ok;
  } lat_t;

  typedef struct packed {
    logic       alive;
    logic       s1p;
    logic       s1n;
    ratio_t     lo;
    ratio_t     hi;
    ratio_t     bb;
    logic       bb_big;
    logic       bb_up;
    logic       bb_rej;
    prod_t      jp_a;
    prod_t      jp_b;
    prod_t      jp_c;
    prod_t      jp_d;
    prod_t      jp_e;
    prod_t      kp_a;
    prod_t      kp_b;
    prod_t      kp_c;
    prod_t      kp_d;
    prod_t      kp_e;
    lat_t       lj;
    lat_t       lk;
    flag_pp_t   pp;
  } fst_t;

  fst_t st_d [FACE_STAGES];
  fst_t st_q [FACE_STAGES];

  function automatic prod_t mul(coord_t a, coord_t b);
    return PRW'(a) * PRW'(b);
  endfunction

  // entry: first one-sided bound, setup of the second, lateral products
  function automatic fst_t stage_in(face_in_t f, logic [31:0] limit);
    fst_t   s;
    ratio_t ra;
    logic   up_a;
    wide_t  deti;
    wide_t  numb;
    s = '0;
    s.alive = 1'b1;
    s.s1p = f.e1i > 0;
    s.s1n = f.e1i < 0;
    s.lo.n = '0;
    s.lo.d = RW'(1);
    s.hi.n = RW'(1);
    s.hi.d = RW'(1);
    ra = mk_ratio(RW'(f.di), RW'(f.e2i));
    up_a = (s.s1p && f.e2i > 0) || (s.s1n && f.e2i < 0);
    if (edge_big(RW'(f.e2i), limit)) begin
      if (up_a) begin
        if (ra.n < 0) s.alive = 1'b0;
        else if (ra.n < ra.d) s.hi = ra;
      end else begin
        if (ra.n > ra.d) s.alive = 1'b0;
        else if (ra.n > 0) s.lo = ra;
      end
    end else if ((!s.s1n && f.di < 0) || (s.s1n && f.di > 0)) begin
      s.alive = 1'b0;
    end
    deti = RW'(f.e1i) - RW'(f.e2i);
    numb = RW'(f.e1i) - RW'(f.di);
    s.bb = mk_ratio(numb, deti);
    s.bb_big = edge_big(deti, limit);
    s.bb_up = (s.s1p && deti > 0) || (s.s1n && deti < 0);
    s.bb_rej = s.s1p ? (numb < 0) : (numb > 0);
    s.jp_a = mul(f.e1i, f.e2j);
    s.jp_b = mul(f.e2i, f.e1j);
    s.jp_c = mul(f.e1i, f.dj);
    s.jp_d = mul(f.e1j, f.di);
    s.jp_e = mul(f.e1i, f.lenj);
    s.kp_a = mul(f.e1i, f.e2k);
    s.kp_b = mul(f.e2i, f.e1k);
    s.kp_c = mul(f.e1i, f.dk);
    s.kp_d = mul(f.e1k, f.di);
    s.kp_e = mul(f.e1i, f.lenk);
    return s;
  endfunction

  function automatic lat_t lat_prep(prod_t pa, prod_t pb, prod_t pc, prod_t pd,
                                    prod_t pe, logic s1p, logic s1n,
                                    logic [31:0] limit);
    lat_t          r;
    wide_t         det;
    wide_t         base;
    wide_t         top;
    logic [RW-1:0] mag;
    logic          keep;
    det = RW'(pa) - RW'(pb);
    base = RW'(pc) - RW'(pd);
    top = base + RW'(pe);
    mag = (det < 0) ? RW'(-det) : RW'(det);
    keep = (s1p && det > 0) || (s1n && det < 0);
    r.big = mag > RW'(limit);
    if (keep) begin
      r.a = mk_ratio(base, det);
      r.b = mk_ratio(top, det);
    end else begin
      r.a = mk_ratio(top, det);
      r.b = mk_ratio(base, det);
    end
    r.ok = s1p ? !(base > 0 || top < 0) : !(base < 0 || top > 0);
    return r;
  endfunction

  // cross products for b<lo, hi<a, lo<a, b<hi
  function automatic flag_pp_t lat_pp(ratio_t a, ratio_t b, ratio_t lo, ratio_t hi);
    flag_pp_t p;
    p[0] = mul_pp(b.n, lo.d);
    p[1] = mul_pp(lo.n, b.d);
    p[2] = mul_pp(a.n, hi.d);
    p[3] = mul_pp(hi.n, a.d);
    p[4] = mul_pp(a.n, lo.d);
    p[5] = mul_pp(lo.n, a.d);
    p[6] = mul_pp(b.n, hi.d);
    p[7] = mul_pp(hi.n, b.d);
    return p;
  endfunction

  function automatic logic [3:0] lat_flags(flag_pp_t p);
    logic [3:0] f;
    f[0] = (pp_sum(p[0]) - pp_sum(p[1])) < 0;
    f[1] = (pp_sum(p[2]) - pp_sum(p[3])) > 0;
    f[2] = (pp_sum(p[4]) - pp_sum(p[5])) > 0;
    f[3] = (pp_sum(p[6]) - pp_sum(p[7])) < 0;
    return f;
  endfunction

  function automatic fst_t side_step(fst_t s_in);
    fst_t       s;
    logic [3:0] flg;
    s = s_in;
    flg = lat_flags(s_in.pp);
    if (s.alive) begin
      if (s.bb_big) begin
        if (s.bb_up) begin
          if (flg[0]) s.alive = 1'b0;
          else if (flg[3]) s.hi = s.bb;
        end else begin
          if (flg[1]) s.alive = 1'b0;
          else if (flg[2]) s.lo = s.bb;
        end
      end else if (s.bb_rej) begin
        s.alive = 1'b0;
      end
    end
    return s;
  endfunction

  function automatic fst_t lat_step(fst_t s_in, lat_t l);
    fst_t       s;
    logic [3:0] flg;
    s = s_in;
    flg = lat_flags(s_in.pp);
    if (s.alive) begin
      if (l.big) begin
        if (flg[0] || flg[1]) begin
          s.alive = 1'b0;
        end else begin
          if (flg[2]) s.lo = l.a;
          if (flg[3]) s.hi = l.b;
        end
      end else begin
        s.alive = l.ok;
      end
    end
    return s;
  endfunction

  always_comb begin
    st_d[0] = stage_in(face_i, limit_i);
    st_d[1] = st_q[0];
    st_d[1].lj = lat_prep(st_q[0].jp_a, st_q[0].jp_b, st_q[0].jp_c, st_q[0].jp_d,
                          st_q[0].jp_e, st_q[0].s1p, st_q[0].s1n, limit_i);
    st_d[1].lk = lat_prep(st_q[0].kp_a, st_q[0].kp_b, st_q[0].kp_c, st_q[0].kp_d,
                          st_q[0].kp_e, st_q[0].s1p, st_q[0].s1n, limit_i);
    st_d[2] = st_q[1];
    st_d[2].pp = lat_pp(st_q[1].bb, st_q[1].bb, st_q[1].lo, st_q[1].hi);
    st_d[3] = side_step(st_q[2]);
    st_d[4] = st_q[3];
    st_d[4].pp = lat_pp(st_q[3].lj.a, st_q[3].lj.b, st_q[3].lo, st_q[3].hi);
    st_d[5] = lat_step(st_q[4], st_q[4].lj);
    st_d[6] = st_q[5];
    st_d[6].pp = lat_pp(st_q[5].lk.a, st_q[5].lk.b, st_q[5].lo, st_q[5].hi);
    st_d[7] = lat_step(st_q[6], st_q[6].lk);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign hit_o = st_q[FACE_STAGES-1].alive;

endmodule
